[rtl/jsu_pkg.sv]
`default_nettype none
package jsu_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;

	localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
	localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
	localparam logic [7:0]  LEAD2         = 8'hC0;
	localparam logic [7:0]  LEAD3         = 8'hE0;
	localparam logic [7:0]  CONT          = 8'h80;

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_ESC,
		PH_HEX0,
		PH_HEX1,
		PH_HEX2,
		PH_HEX3,
		PH_ERR
	} phase_t;

	// One decoded input byte: up to three output bytes plus end-of-string status.
	typedef struct packed {
		logic [1:0]  cnt;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic        last;
		logic        err;
		logic [15:0] len;
	} entry_t;

	// Bit 4 is set when the character is a hex digit, bits 3:0 carry its value.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic [7:0] escape_char(input logic [7:0] e);
		logic [7:0] r;
		r = e;
		if (e == CH_N) begin
			r = 8'h0A;
		end else if (e == CH_R) begin
			r = 8'h0D;
		end else if (e == CH_T) begin
			r = 8'h09;
		end else if (e == CH_B) begin
			r = 8'h08;
		end else if (e == CH_F) begin
			r = 8'h0C;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/json_string_unescape.sv]
// JSON string body unescaper with UTF-8 output.
// Input stream: s_tdata carries one raw byte of the escaped body, s_tlast
// marks the final byte of a string. Output stream: one decoded byte per
// transfer; m_tuser says whether m_tdata[7:0] holds a byte, m_tlast marks
// the final item of a string, which also carries the error flag and the
// decoded length. A string whose last byte decodes to nothing still ends
// with one item that has m_tuser low.
// The decoder front takes one input byte every cycle while its four-entry
// queue has room; a byte is decoded in the cycle it is taken and its result
// can appear on the output in the next cycle. The output side drains one
// item per cycle while m_tready is high, so a \u escape making three bytes
// holds its queue entry until all are sent, while the front keeps accepting.
// When the receiver stalls, the queue fills and s_tready drops after four
// pending entries; nothing is lost. Register out_limit (APB address 0,
// reset 65535) sets the output capacity including a terminator.
// Reset empties the queue, clears the decode state and restores out_limit.
`default_nettype none
module json_string_unescape (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] out_byte, [8] decode_error,
	                                    // [24:9] decoded_length, [31:25] zero
	output logic             m_tuser,   // [0] byte_valid
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import jsu_pkg::*;

	logic [15:0] out_limit_q;
	logic        take;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_not_empty;
	entry_t      fr_entry;
	entry_t      q_head;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == 1'b0) ? {16'd0, out_limit_q} : 32'd0;
	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= 16'hFFFF;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			out_limit_q <= pwdata[15:0];
		end
	end

	jsu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.limit   (out_limit_q),
		.push    (push),
		.entry   (fr_entry)
	);

	jsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (fr_entry),
		.pop       (pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_not_empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

[rtl/jsu_front.sv]
`default_nettype none
module jsu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire logic [7:0]     in_byte,
	input  wire logic           in_last,
	input  wire logic [15:0]    limit,
	output logic                push,
	output jsu_pkg::entry_t     entry
);
	import jsu_pkg::*;

	phase_t      phase_q, phase_n;
	logic [15:0] acc_q, acc_n;
	logic [15:0] wcnt_q, wcnt_n;
	logic        err_q, err_n;
	logic [1:0]  n;
	logic [7:0]  b0, b1, b2;
	logic [4:0]  hd;
	logic [16:0] wcnt_x, lim_x;

	assign wcnt_x = {1'b0, wcnt_q};
	assign lim_x  = {1'b0, limit};

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		err_n   = err_q;
		n       = 2'd0;
		b0      = 8'h00;
		b1      = 8'h00;
		b2      = 8'h00;
		hd      = hex_digit(in_byte);
		unique case (phase_q)
			PH_NORMAL: begin
				if (wcnt_x + 17'd1 >= lim_x) begin
					phase_n = PH_ERR;
					err_n   = 1'b1;
				end else if (in_byte == CH_BSLASH) begin
					if (in_last) begin
						phase_n = PH_ERR;
						err_n   = 1'b1;
					end else begin
						phase_n = PH_ESC;
					end
				end else begin
					n  = 2'd1;
					b0 = in_byte;
				end
			end
			PH_ESC: begin
				if (in_byte == CH_U) begin
					if (in_last) begin
						phase_n = PH_ERR;
						err_n   = 1'b1;
					end else begin
						phase_n = PH_HEX0;
						acc_n   = 16'h0000;
					end
				end else begin
					phase_n = PH_NORMAL;
					n       = 2'd1;
					b0      = escape_char(in_byte);
				end
			end
			PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
				if (!hd[4]) begin
					phase_n = PH_ERR;
					err_n   = 1'b1;
				end else begin
					acc_n = {acc_q[11:0], hd[3:0]};
					if (phase_q != PH_HEX3) begin
						if (in_last) begin
							phase_n = PH_ERR;
							err_n   = 1'b1;
						end else begin
							phase_n = phase_t'(phase_q + 3'd1);
						end
					end else begin
						phase_n = PH_NORMAL;
						if (acc_n < CP_TWO_BYTE) begin
							n  = 2'd1;
							b0 = acc_n[7:0];
						end else if (acc_n < CP_THREE_BYTE) begin
							if (wcnt_x + 17'd3 > lim_x) begin
								phase_n = PH_ERR;
								err_n   = 1'b1;
							end else begin
								n  = 2'd2;
								b0 = LEAD2 | {3'b000, acc_n[10:6]};
								b1 = CONT | {2'b00, acc_n[5:0]};
							end
						end else begin
							if (wcnt_x + 17'd4 > lim_x) begin
								phase_n = PH_ERR;
								err_n   = 1'b1;
							end else begin
								n  = 2'd3;
								b0 = LEAD3 | {4'b0000, acc_n[15:12]};
								b1 = CONT | {2'b00, acc_n[11:6]};
								b2 = CONT | {2'b00, acc_n[5:0]};
							end
						end
					end
				end
			end
			default: begin
				phase_n = PH_ERR;
				err_n   = 1'b1;
			end
		endcase
		wcnt_n = wcnt_q + {14'd0, n};
	end

	assign push       = take && ((n != 2'd0) || in_last);
	assign entry.cnt  = n;
	assign entry.b0   = b0;
	assign entry.b1   = b1;
	assign entry.b2   = b2;
	assign entry.last = in_last;
	assign entry.err  = err_n;
	assign entry.len  = wcnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			acc_q   <= 16'h0000;
			wcnt_q  <= 16'h0000;
			err_q   <= 1'b0;
		end else if (take) begin
			if (in_last) begin
				phase_q <= PH_NORMAL;
				acc_q   <= 16'h0000;
				wcnt_q  <= 16'h0000;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				wcnt_q  <= wcnt_n;
				err_q   <= err_n;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/jsu_queue.sv]
`default_nettype none
module jsu_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire jsu_pkg::entry_t wr_entry,
	input  wire logic           pop,
	output jsu_pkg::entry_t     head,
	output logic                not_empty,
	output logic                full
);
	import jsu_pkg::*;

	entry_t           slots [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     count_q;

	assign head      = slots[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == (QAW+1)'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue read while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) + (QAW+1)'($past(push))
			- (QAW+1)'($past(pop)))) else $error("queue fill count drifted");
`endif

endmodule
`default_nettype wire

[rtl/jsu_back.sv]
`default_nettype none
module jsu_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jsu_pkg::entry_t head,
	input  wire logic            head_valid,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [31:0]          m_tdata,
	output logic                 m_tuser,
	output logic                 m_tlast
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic       final_item;
	logic       send;
	logic       has_byte;
	logic       at_end;
	logic [7:0] sel;

	assign has_byte   = (head.cnt != 2'd0);
	assign final_item = !has_byte || (idx_q == head.cnt - 2'd1);
	assign at_end     = head.last && final_item;
	assign m_tvalid   = head_valid;
	assign send       = head_valid && m_tready;
	assign pop        = send && final_item;

	always_comb begin
		unique case (idx_q)
			2'd0:    sel = head.b0;
			2'd1:    sel = head.b1;
			default: sel = head.b2;
		endcase
	end

	assign m_tdata[7:0]   = has_byte ? sel : 8'h00;
	assign m_tdata[8]     = at_end ? head.err : 1'b0;
	assign m_tdata[24:9]  = at_end ? head.len : 16'h0000;
	assign m_tdata[31:25] = 7'd0;
	assign m_tuser        = has_byte;
	assign m_tlast        = at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (send) begin
			idx_q <= final_item ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

[sim/jsu_checker.sv]
module jsu_checker #(
	parameter logic [2:0] LIMIT_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [7:0] out_byte, [8] decode_error, [24:9] decoded_length
	input  logic        m_tuser,   // [0] byte_valid
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import jsu_pkg::*;

	typedef struct {
		logic [7:0]  data;
		logic        valid;
		logic        eos;
		logic        err;
		logic [15:0] len;
	} decoded_t;

	decoded_t    decoded_q[$];
	decoded_t    burst[$];
	logic [15:0] out_limit;
	phase_t      phase;
	logic [15:0] code_acc;
	int          written;
	logic        err_seen;

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0");
		end else if (c >= "a" && c <= "f") begin
			return int'(c) - int'("a") + 10;
		end else if (c >= "A" && c <= "F") begin
			return int'(c) - int'("A") + 10;
		end
		return -1;
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		case (c)
			CH_N: return 8'h0A;
			CH_R: return 8'h0D;
			CH_T: return 8'h09;
			CH_B: return 8'h08;
			CH_F: return 8'h0C;
			default: return c;
		endcase
	endfunction

	task automatic restart_string();
		phase = PH_NORMAL;
		code_acc = '0;
		written = 0;
		err_seen = 1'b0;
	endtask

	task automatic abort_string();
		err_seen = 1'b1;
		phase = PH_ERR;
	endtask

	task automatic put(input logic [7:0] b);
		burst.push_back('{b, 1'b1, 1'b0, 1'b0, 16'h0000});
		written++;
	endtask

	// Works out the bytes that one request produces and queues them.
	task automatic decode_byte(input logic [7:0] c, input logic lst);
		int d;
		logic [15:0] cp;
		decoded_t tail;
		burst.delete();
		case (phase)
			PH_NORMAL: begin
				if (written + 1 >= out_limit) begin
					abort_string();
				end else if (c == CH_BSLASH) begin
					if (lst) abort_string();
					else phase = PH_ESC;
				end else begin
					put(c);
				end
			end
			PH_ESC: begin
				if (c == CH_U) begin
					if (lst) begin
						abort_string();
					end else begin
						phase = PH_HEX0;
						code_acc = '0;
					end
				end else begin
					phase = PH_NORMAL;
					put(unescape(c));
				end
			end
			PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
				d = nibble_of(c);
				if (d < 0) begin
					abort_string();
				end else begin
					code_acc = {code_acc[11:0], 4'(d)};
					if (phase != PH_HEX3) begin
						if (lst) abort_string();
						else phase = phase_t'(phase + 1);
					end else begin
						phase = PH_NORMAL;
						cp = code_acc;
						if (cp < CP_TWO_BYTE) begin
							put(cp[7:0]);
						end else if (cp < CP_THREE_BYTE) begin
							if (written + 3 > out_limit) begin
								abort_string();
							end else begin
								put(LEAD2 | {3'b000, cp[10:6]});
								put(CONT | {2'b00, cp[5:0]});
							end
						end else begin
							if (written + 4 > out_limit) begin
								abort_string();
							end else begin
								put(LEAD3 | {4'b0000, cp[15:12]});
								put(CONT | {2'b00, cp[11:6]});
								put(CONT | {2'b00, cp[5:0]});
							end
						end
					end
				end
			end
			default: abort_string();
		endcase
		if (lst) begin
			// The string status rides on the last byte, or on an empty item.
			if (burst.size() == 0) begin
				burst.push_back('{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000});
			end
			tail = burst[burst.size() - 1];
			tail.eos = 1'b1;
			tail.err = err_seen;
			tail.len = written[15:0];
			burst[burst.size() - 1] = tail;
			restart_string();
		end
		foreach (burst[i]) decoded_q.push_back(burst[i]);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			out_limit = 16'hFFFF;
			restart_string();
			decoded_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) begin
				out_limit = pwdata[15:0];
			end
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					$error("output with nothing expected: m_tdata %h, m_tuser %b, m_tlast %b",
						m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					check_field("out_byte", want.data, m_tdata[7:0]);
					check_field("byte_valid", want.valid, m_tuser);
					check_field("end_of_string", want.eos, m_tlast);
					check_field("decode_error", want.err, m_tdata[8]);
					check_field("decoded_length", want.len, m_tdata[24:9]);
				end
			end
			pending = decoded_q.size();
		end
	end

endmodule

[sim/tb.sv]
module tb;
	import jsu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] LIMIT_ADDR   = 3'd0;
	localparam int         STALL_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 16;

	typedef logic [7:0] bytes_t[$];

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] in_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [7:0] out_byte, [8] decode_error, [24:9] decoded_length
	logic        m_tuser;   // [0] byte_valid
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int pending;
	int tx_idle;
	int rx_idle;
	int bytes_sent;
	int strings_sent;
	int limits_used;
	int quiet_cycles;

	json_string_unescape uut (.*);

	jsu_checker #(.LIMIT_ADDR(LIMIT_ADDR)) decode_check (.*);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle);
	end

	// Ends the run when nothing has moved on any port for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic bytes_t text_bytes(input string s);
		bytes_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10) return 8'h30 + n;
		return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic lst);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_body(input bytes_t body);
		foreach (body[i]) push_byte(body[i], i == body.size() - 1);
		bytes_sent += body.size();
		strings_sent++;
	endtask

	task automatic write_limit(input logic [15:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= {16'h0000, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		limits_used++;
	endtask

	// Drops valid and waits until every decoded byte has come out.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_string();
		bytes_t body;
		int units;
		int kind;
		int digits;
		logic [7:0] c;
		logic [15:0] cp;
		string simple;
		string junk;
		simple = "\"\\/nrtbf";
		junk = "gGxz:@`/ ";
		units = $urandom_range(8, 1);
		for (int k = 0; k < units; k++) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				body.push_back(8'($urandom));
			end else if (kind < 60) begin
				body.push_back(CH_BSLASH);
				body.push_back(simple[$urandom_range(simple.len() - 1)]);
			end else if (kind < 65) begin
				c = 8'($urandom);
				if (c == CH_U) c = "q";
				body.push_back(CH_BSLASH);
				body.push_back(c);
			end else if (kind < 94) begin
				case ($urandom_range(2))
					0: cp = 16'($urandom_range(16'h007F));
					1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
					default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
				endcase
				body.push_back(CH_BSLASH);
				body.push_back(CH_U);
				for (int j = 3; j >= 0; j--) body.push_back(hex_char(cp[4*j +: 4]));
			end else begin
				// Broken escapes: a bad digit inside \u, or the string ends mid-escape.
				digits = $urandom_range(3);
				if ($urandom_range(1)) begin
					body.push_back(CH_BSLASH);
					body.push_back(CH_U);
					repeat (digits) body.push_back(hex_char(4'($urandom)));
					body.push_back($urandom_range(1) ? (8'h80 | 8'($urandom))
						: junk[$urandom_range(junk.len() - 1)]);
				end else begin
					body.push_back(CH_BSLASH);
					if ($urandom_range(1)) begin
						body.push_back(CH_U);
						repeat (digits) body.push_back(hex_char(4'($urandom)));
					end
					break;
				end
			end
		end
		send_body(body);
	endtask

	task automatic random_batch(input int count);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < count) random_string();
	endtask

	initial begin
		bytes_t body;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet_cycles = 0;
		bytes_sent = 0;
		strings_sent = 0;
		limits_used = 0;
		tx_idle = 21;
		rx_idle = 81;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_limit(16'hFFFF);
		// Every simple escape and an unknown one, framed by the byte extremes.
		body = text_bytes("\\n\\r\\t\\b\\f\\\"\\\\\\/\\q");
		body.push_front(8'h00);
		body.push_back(8'hFF);
		send_body(body);
		send_body(text_bytes("\\uFfFf"));
		// A trailing backslash, then a \u escape cut short by the last byte.
		send_body(text_bytes("\\"));
		send_body(text_bytes("\\u0"));
		random_batch(55);

		settle();
		write_limit(16'd2);
		random_batch(30);

		tx_idle = 81;
		rx_idle = 21;
		settle();
		write_limit(16'd3);
		random_batch(30);
		settle();
		write_limit(16'($urandom_range(12, 4)));
		random_batch(45);

		tx_idle = 0;
		rx_idle = 0;
		settle();
		write_limit(16'd5);
		random_batch(30);
		settle();
		write_limit(16'hFFFF);
		random_batch(50);
		settle();

		$display("Decoded %0d bytes in %0d strings over %0d out_limit writes (2 to 65535),",
			bytes_sent, strings_sent, limits_used);
		$display("with escapes, \\u forms, broken escapes and capacity overruns.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
